[rtl/core/gaussian_density_eval_core_macros.svh]
// Assertion macros shared by the Gaussian density core
`ifndef GAUSSIAN_DENSITY_EVAL_CORE_MACROS_SVH
`define GAUSSIAN_DENSITY_EVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define GDE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define GDE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/gde_pkg.sv]
// Package: widths, types and the exp table builder for the Gaussian density core
`timescale 1ns / 1ps
package gde_pkg;

  localparam int EXP_TABLE_ENTRIES = 256;

  localparam int DATA_W     = 32;
  localparam int CFG_AW     = 3;
  localparam int DIV_W      = DATA_W + 1;          // 2*variance
  localparam int ARG_W      = 20;                  // exponent argument below 16.0 in Q.16
  localparam int REM_W      = DIV_W + ARG_W;
  localparam int DIV_STEPS  = ARG_W / 2;           // two quotient bits per stage
  localparam int FRAC_W     = 20;
  localparam int IDX_W      = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int P_W        = ARG_W + IDX_W;
  localparam int EXP_W      = DATA_W + 1;
  localparam int PROD_W     = DATA_W + EXP_W;
  localparam int TAYLOR_TERMS = 14;
  localparam int NUM_W      = 48;
  localparam int SQRT_STEPS = DATA_W;
  localparam int CNT_W      = $clog2(NUM_W);

  localparam logic [DATA_W-1:0] INV_SQRT_2PI_Q32 = 32'd1713444047;
  localparam logic [DATA_W-1:0] VARIANCE_RESET   = 32'd65536;

  typedef enum logic {
    REG_MEAN,
    REG_VARIANCE
  } reg_idx_t;

  typedef enum logic [2:0] {
    CO_LOAD,
    CO_SQRT,
    CO_PREP,
    CO_DIV,
    CO_DONE
  } coef_state_t;

  typedef struct packed {
    logic             ovf;
    logic [ARG_W-1:0] arg;
  } arg_t;

  typedef struct packed {
    logic [DATA_W-1:0] density;
    logic              saturated;
  } res_t;

  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_ENTRIES];

  // Samples of exp(-t) over 0..16, built from a Taylor step ratio
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] prod;
    s    = (64'd1 << 36) / 64'(EXP_TABLE_ENTRIES);
    term = 64'd1 << 32;
    r    = term;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      prod = term * s;
      term = (prod >> 32) / 64'(k);
      if (k % 2 == 1) r = r - term;
      else            r = r + term;
    end
    tab[0] = EXP_W'(64'd1 << 32);
    for (int k = 1; k <= EXP_TABLE_ENTRIES; k++) begin
      prod   = 64'(tab[k-1]) * r + (64'd1 << 31);
      tab[k] = EXP_W'(prod >> 32);
    end
    return tab;
  endfunction

endpackage

[rtl/core/gde_if.sv]
// Channel interfaces: sample input and density result
`timescale 1ns / 1ps
interface gde_in_if import gde_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gde_out_if import gde_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] density;
  logic              saturated;
  modport source (output valid, output density, output saturated, input ready);
  modport sink   (input valid, input density, input saturated, output ready);
endinterface

[rtl/core/gde_coef.sv]
// Sequential unit: coefficient 1/sqrt(2*pi*var) in Q8.24 via isqrt and division
`timescale 1ns / 1ps
module gde_coef import gde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] var_eff,
  output logic [DATA_W-1:0] coef,
  output logic              busy
);

  coef_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [63:0]        v_r, res_r, bit_r;
  logic [63:0]        tsum;
  logic [NUM_W-1:0]   num_r;
  logic [DATA_W-1:0]  rem_r;
  logic [DATA_W-1:0]  q;
  logic [DATA_W:0]    rsh, rdif;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CO_LOAD;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CO_LOAD: state_nxt = CO_SQRT;
      CO_SQRT: if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = CO_PREP;
      CO_PREP: state_nxt = CO_DIV;
      CO_DIV:  if (cnt_r == CNT_W'(NUM_W - 1)) state_nxt = CO_DONE;
      CO_DONE: state_nxt = CO_DONE;
      default: state_nxt = CO_LOAD;
    endcase
    if (start) state_nxt = CO_LOAD;
  end

  // Datapath helpers
  always_comb begin
    tsum = res_r + bit_r;
    q    = (res_r[DATA_W-1:0] == '0) ? DATA_W'(1) : res_r[DATA_W-1:0];
    rsh  = {rem_r, num_r[NUM_W-1]};
    rdif = rsh - {1'b0, q};
  end

  // Step the root digit by digit, then the restoring division
  always_ff @(posedge clk) begin
    unique case (state_r)
      CO_LOAD: begin
        v_r   <= {var_eff, 32'b0};
        res_r <= '0;
        bit_r <= 64'd1 << 62;
        cnt_r <= '0;
      end
      CO_SQRT: begin
        if (v_r >= tsum) begin
          v_r   <= v_r - tsum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
      end
      CO_PREP: begin
        num_r <= (NUM_W'(INV_SQRT_2PI_Q32) << 16) + NUM_W'(q >> 1);
        rem_r <= '0;
        cnt_r <= '0;
      end
      CO_DIV: begin
        if (!rdif[DATA_W]) begin
          rem_r <= rdif[DATA_W-1:0];
          num_r <= {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rsh[DATA_W-1:0];
          num_r <= {num_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign coef = num_r[DATA_W-1:0];
  assign busy = (state_r != CO_DONE);

endmodule

[rtl/core/gde_argdiv.sv]
// Pipeline front: difference, square and pipelined divide by 2*var
`timescale 1ns / 1ps
module gde_argdiv import gde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [DATA_W-1:0] sample,
  input  logic [DATA_W-1:0] mean,
  input  logic [DIV_W-1:0]  divisor,
  output logic              dn_valid,
  input  logic              dn_ready,
  output arg_t              dn_arg
);

  localparam int NS = DIV_STEPS + 3;

  logic [NS-1:0]       v_r, v_nxt;
  logic [NS:0]         ld;
  logic [DATA_W:0]     diff;
  logic [DATA_W-1:0]   ad_nxt, ad_r;
  logic [2*DATA_W-1:0] d2_nxt, d2_r;
  logic [2*DATA_W-1:0] lim;
  logic [REM_W-1:0]    rem_r   [0:DIV_STEPS];
  logic [REM_W-1:0]    rem_nxt [1:DIV_STEPS];
  logic [ARG_W-1:0]    quo_r   [0:DIV_STEPS];
  logic [ARG_W-1:0]    quo_nxt [1:DIV_STEPS];
  logic [DIV_STEPS:0]  ovf_r;
  logic [REM_W-1:0]    rin;
  logic [REM_W:0]      dsh, t;
  logic [ARG_W-1:0]    qacc;
  int                  j;

  // Stage k advances when empty or when the next stage advances
  assign ld[NS] = dn_ready;
  for (genvar k = 0; k < NS; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end
  assign up_ready = ld[0];

  // Valid bits move with the data
  assign v_nxt = (ld[NS-1:0] & {v_r[NS-2:0], up_valid}) | (~ld[NS-1:0] & v_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  // Absolute difference and its square
  always_comb begin
    diff   = {sample[DATA_W-1], sample} - {mean[DATA_W-1], mean};
    ad_nxt = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    d2_nxt = ad_r * ad_r;
    lim    = (2*DATA_W)'(divisor) << ARG_W;
  end

  // Two restoring quotient bits per stage
  always_comb begin
    rin  = '0;
    dsh  = '0;
    t    = '0;
    qacc = '0;
    j    = 0;
    for (int m = 1; m <= DIV_STEPS; m++) begin
      rin  = rem_r[m-1];
      qacc = quo_r[m-1];
      for (int b = 1; b >= 0; b--) begin
        j   = ARG_W - 2*m + b;
        dsh = {1'b0, REM_W'(divisor)} << j;
        t   = {1'b0, rin} - dsh;
        if (!t[REM_W]) begin
          rin  = t[REM_W-1:0];
          qacc = qacc | (ARG_W'(1) << j);
        end
      end
      rem_nxt[m] = rin;
      quo_nxt[m] = qacc;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ld[0]) ad_r <= ad_nxt;
    if (ld[1]) d2_r <= d2_nxt;
    if (ld[2]) begin
      ovf_r[0] <= (d2_r >= lim);
      rem_r[0] <= REM_W'(d2_r);
      quo_r[0] <= '0;
    end
    for (int m = 1; m <= DIV_STEPS; m++) begin
      if (ld[m+2]) begin
        ovf_r[m] <= ovf_r[m-1];
        rem_r[m] <= rem_nxt[m];
        quo_r[m] <= quo_nxt[m];
      end
    end
  end

  assign dn_valid   = v_r[NS-1];
  assign dn_arg.ovf = ovf_r[DIV_STEPS];
  assign dn_arg.arg = quo_r[DIV_STEPS];

endmodule

[rtl/core/gde_expmul.sv]
// Pipeline back: exp table lookup, interpolation, coefficient product, rounding
`timescale 1ns / 1ps
module gde_expmul import gde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  arg_t              up_arg,
  input  logic [DATA_W-1:0] coef,
  output logic              dn_valid,
  input  logic              dn_ready,
  output res_t              dn_res
);

  localparam int NS = 6;
  localparam exp_tab_t EXP_TAB = build_exp_tab();

  logic [NS-1:0]             v_r, v_nxt;
  logic [NS:0]               ld;
  logic [NS-2:0]             ovf_r;
  logic [P_W-1:0]            p;
  logic [IDX_W-1:0]          idx_nxt, idx_r;
  logic [FRAC_W-1:0]         frac_nxt, frac_r, frac1_r;
  logic [EXP_W-1:0]          ehi_r, ehi2_r, diff_r, mul_r, e_r;
  logic [EXP_W+FRAC_W-1:0]   dprod;
  logic [PROD_W-1:0]         prod_r;
  logic [PROD_W:0]           rnd;
  res_t                      res_r, res_nxt;

  // Stage k advances when empty or when the next stage advances
  assign ld[NS] = dn_ready;
  for (genvar k = 0; k < NS; k++) begin : g_ld
    assign ld[k] = !v_r[k] || ld[k+1];
  end
  assign up_ready = ld[0];

  assign v_nxt = (ld[NS-1:0] & {v_r[NS-2:0], up_valid}) | (~ld[NS-1:0] & v_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  // Split the scaled argument into table index and fraction
  always_comb begin
    p        = P_W'(up_arg.arg) * P_W'(EXP_TABLE_ENTRIES);
    idx_nxt  = p[P_W-1:FRAC_W];
    frac_nxt = p[FRAC_W-1:0];
    if (idx_nxt >= IDX_W'(EXP_TABLE_ENTRIES)) begin
      idx_nxt  = IDX_W'(EXP_TABLE_ENTRIES - 1);
      frac_nxt = '1;
    end
  end

  // Interpolation, product and rounding
  always_comb begin
    dprod = diff_r * frac1_r;
    rnd   = {1'b0, prod_r} + (PROD_W + 1)'(64'd1 << 31);
    if (ovf_r[NS-2]) begin
      res_nxt.density   = '0;
      res_nxt.saturated = 1'b0;
    end else if (rnd[PROD_W:2*DATA_W] != '0) begin
      res_nxt.density   = '1;
      res_nxt.saturated = 1'b1;
    end else begin
      res_nxt.density   = rnd[2*DATA_W-1:DATA_W];
      res_nxt.saturated = 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      idx_r    <= idx_nxt;
      frac_r   <= frac_nxt;
      ovf_r[0] <= up_arg.ovf;
    end
    if (ld[1]) begin
      ehi_r    <= EXP_TAB[idx_r];
      diff_r   <= EXP_TAB[idx_r] - EXP_TAB[idx_r + 1'b1];
      frac1_r  <= frac_r;
      ovf_r[1] <= ovf_r[0];
    end
    if (ld[2]) begin
      mul_r    <= dprod[EXP_W+FRAC_W-1:FRAC_W];
      ehi2_r   <= ehi_r;
      ovf_r[2] <= ovf_r[1];
    end
    if (ld[3]) begin
      e_r      <= ehi2_r - mul_r;
      ovf_r[3] <= ovf_r[2];
    end
    if (ld[4]) begin
      prod_r   <= coef * e_r;
      ovf_r[4] <= ovf_r[3];
    end
    if (ld[5]) res_r <= res_nxt;
  end

  assign dn_valid = v_r[NS-1];
  assign dn_res   = res_r;

endmodule

[rtl/core/gaussian_density_eval_core.sv]
// Throughput: one sample per cycle through a 19-stage pipeline with per-stage valid bits,
// while the coefficient is not busy and the output is not stalled.
// The coefficient unit runs a load state, 32 root steps, a prep state and 48 divide steps
// after reset and after each variance write; input ready stays low meanwhile.
// Reset (synchronous, rst_n low) clears valid bits, sets mean 0 and variance 1.0.
`timescale 1ns / 1ps
`include "gaussian_density_eval_core_macros.svh"
module gaussian_density_eval_core import gde_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  gde_in_if.sink            in_ch,
  gde_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] mean_r, variance_r;
  logic [DATA_W-1:0] var_eff;
  logic              cfg_wr, var_wr;
  reg_idx_t          reg_idx;
  logic              coef_busy;
  logic [DATA_W-1:0] coef;
  logic              ad_ready, ad_valid;
  logic              mid_valid, mid_ready;
  arg_t              mid_arg;
  res_t              res;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_AW-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign var_wr  = cfg_wr && (reg_idx == REG_VARIANCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r     <= '0;
      variance_r <= VARIANCE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MEAN:     mean_r     <= pwdata;
        REG_VARIANCE: variance_r <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MEAN:     prdata = mean_r;
      REG_VARIANCE: prdata = variance_r;
    endcase
  end

  // Zero variance counts as the smallest positive value
  assign var_eff = (variance_r == '0) ? DATA_W'(1) : variance_r;

  gde_coef u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (var_wr),
    .var_eff (var_eff),
    .coef    (coef),
    .busy    (coef_busy)
  );

  // Hold input while the coefficient is being rebuilt
  assign ad_valid    = in_ch.valid && !coef_busy;
  assign in_ch.ready = ad_ready && !coef_busy;

  gde_argdiv u_argdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ad_valid),
    .up_ready (ad_ready),
    .sample   (in_ch.sample),
    .mean     (mean_r),
    .divisor  ({var_eff, 1'b0}),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_arg   (mid_arg)
  );

  gde_expmul u_expmul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_arg   (mid_arg),
    .coef     (coef),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_res   (res)
  );

  assign out_ch.density   = res.density;
  assign out_ch.saturated = res.saturated;

  // No transfer while the coefficient is stale; a variance write restarts it;
  // a clipped result reads full scale
  `GDE_ASSERT_IMP(a_no_xfer_busy, clk, rst_n, in_ch.valid && in_ch.ready, !coef_busy, "transfer while coefficient busy")
  `GDE_ASSERT_NXT(a_var_wr_busy, clk, rst_n, var_wr, coef_busy, "variance write did not restart coefficient")
  `GDE_ASSERT_IMP(a_sat_full, clk, rst_n, out_ch.valid && out_ch.saturated, out_ch.density == '1, "saturated result not full scale")

endmodule
